[rtl/sha256_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-256 hasher package
// Round constants, initial hash words, rotate and byte-lane helpers and the sequencer
// state type.
// ----------------------------------------------------------------------------
package sha256_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } core_ctl_type;

   localparam int unsigned NUM_ROUNDS = 64;
   localparam logic [7:0] PAD_BYTE = 8'h80;

   function automatic logic [31:0] init_word(input logic [2:0] idx);
      logic [31:0] r;
      begin
         case (idx)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
         endcase
         return r;
      end
   endfunction

   function automatic logic [31:0] round_const(input logic [5:0] t);
      logic [31:0] k [64];
      begin
         k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
            32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
            32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
            32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
            32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
            32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
            32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
            32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
            32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
            32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
            32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
         return k[t];
      end
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
      return (v >> s) | (v << (32 - s));
   endfunction

   // place a byte in its big-endian lane of a word, other lanes zero
   function automatic logic [31:0] lane_word(input logic [7:0] b, input logic [1:0] lane);
      logic [31:0] r;
      begin
         case (lane)
            2'd0: r = {b, 24'd0};
            2'd1: r = {8'd0, b, 16'd0};
            2'd2: r = {16'd0, b, 8'd0};
            default: r = {24'd0, b};
         endcase
         return r;
      end
   endfunction

endpackage

[rtl/sha256_sched.sv]
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word sliding window; supplies W[t] for each round and shifts once.
// ----------------------------------------------------------------------------
module sha256_sched (
   input  logic              clock,
   input  logic              load,
   input  logic [16*32-1:0]  block,
   input  logic              advance,
   output logic [31:0]       w_out
);
   import sha256_pkg::*;

   logic [31:0] win_ff [16];
   logic [31:0] next_w;
   logic [31:0] s0;
   logic [31:0] s1;

   // next schedule word from the window
   always_comb begin
      s0 = rotr(win_ff[1], 7) ^ rotr(win_ff[1], 18) ^ (win_ff[1] >> 3);
      s1 = rotr(win_ff[14], 17) ^ rotr(win_ff[14], 19) ^ (win_ff[14] >> 10);
      next_w = s1 + win_ff[9] + s0 + win_ff[0];
   end

   assign w_out = win_ff[0];

   // load a block or slide by one word
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < 16; i++) begin
            win_ff[i] <= block[(15-i)*32 +: 32];
         end
      end else if (advance) begin
         for (int i = 0; i < 15; i++) begin
            win_ff[i] <= win_ff[i+1];
         end
         win_ff[15] <= next_w;
      end
   end

endmodule

[rtl/sha256_core.sv]
// ----------------------------------------------------------------------------
// SHA-256 compression core
// One round per cycle, 64 rounds, then folds into the chaining value.
// ----------------------------------------------------------------------------
module sha256_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic                       reinit,
   input  logic [16*32-1:0]           block,
   output sha256_pkg::core_ctl_type   ctl,
   output logic [8*32-1:0]            hash
);
   import sha256_pkg::*;

   logic [31:0] h_ff [8];
   logic [31:0] v_ff [8];
   logic [5:0]  rnd_ff;
   logic        busy_ff;
   logic        fold_ff;
   logic [31:0] w_t;
   logic [31:0] t1;
   logic [31:0] t2;

   sha256_sched u_sched (
      .clock   (clock),
      .load    (start),
      .block   (block),
      .advance (busy_ff),
      .w_out   (w_t)
   );

   // one round of the shared unit
   always_comb begin
      t1 = v_ff[7] + (rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25))
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + round_const(rnd_ff) + w_t;
      t2 = (rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22))
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // round counter and control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fold_ff <= 1'b0;
         rnd_ff  <= '0;
      end else begin
         fold_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            rnd_ff  <= '0;
         end else if (busy_ff) begin
            rnd_ff <= rnd_ff + 6'd1;
            if (rnd_ff == 6'(NUM_ROUNDS - 1)) begin
               busy_ff <= 1'b0;
               fold_ff <= 1'b1;
            end
         end
      end
   end

   // working variables
   always_ff @(posedge clock) begin
      if (start) begin
         for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
      end else if (busy_ff) begin
         v_ff[7] <= v_ff[6];
         v_ff[6] <= v_ff[5];
         v_ff[5] <= v_ff[4];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[3] <= v_ff[2];
         v_ff[2] <= v_ff[1];
         v_ff[1] <= v_ff[0];
         v_ff[0] <= t1 + t2;
      end
   end

   // chaining value
   always_ff @(posedge clock) begin
      if (reset || reinit) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= init_word(3'(i));
      end else if (fold_ff) begin
         for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) hash[(7-i)*32 +: 32] = h_ff[i];
   end

   assign ctl.start = start;
   assign ctl.busy  = busy_ff;
   assign ctl.done  = fold_ff;

endmodule

[rtl/sha256_message_hasher_unit.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hasher
// Byte stream in, eight digest words out, standard padding and length.
// ----------------------------------------------------------------------------
// A byte is accepted while idle; a byte that fills a block is then followed by
// load, 64 rounds, fold into the chaining value and one decide state.
// Message end: the padding block (and a second block when needed) is hashed,
// then 8 digest words, one per cycle without stalls.
// No bytes are accepted while a block is being hashed.
// Reset: synchronous; restores the initial chaining value, clears length and sequencer.
module sha256_message_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last
   input  logic        req_tuser,   // no_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic        rsp_tlast,   // last_word
   output logic [2:0]  rsp_tuser    // word_index
);
   import sha256_pkg::*;

   state_type    state_ff, state_in;
   logic [31:0]  buf_ff [16];
   logic [60:0]  len_ff;
   logic         fin_ff;     // padding still to be built after current block
   logic         pad2_ff;    // length block still to be built
   logic         emit_ff;    // message ended, digest pending
   logic [2:0]   idx_ff;
   logic         start;
   logic         reinit;
   logic [16*32-1:0] blk;
   logic [8*32-1:0]  hash;
   core_ctl_type ctl;
   logic         acc;
   logic         fill;
   logic [5:0]   pos;
   logic [63:0]  bits;

   assign acc  = req_tvalid && req_tready;
   assign fill = acc && !req_tuser && (pos == 6'd63);
   assign pos  = len_ff[5:0];
   assign bits = {len_ff, 3'b000};

   always_comb begin
      for (int i = 0; i < 16; i++) blk[(15-i)*32 +: 32] = buf_ff[i];
   end

   sha256_core u_core (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .reinit (reinit),
      .block  (blk),
      .ctl    (ctl),
      .hash   (hash)
   );

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      start      = 1'b0;
      reinit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (fill) state_in = ST_LOAD;
            else if (acc && req_tlast) state_in = ST_PAD;
         end
         ST_PAD: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            start    = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (ctl.done) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (fin_ff) state_in = ST_PAD;
            else if (pad2_ff) state_in = ST_LOAD;
            else if (emit_ff) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready && idx_ff == 3'd7) begin
               reinit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // block buffer: pack bytes, build padding and length words
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (acc && !req_tuser) begin
               if (pos[1:0] == 2'd0)
                  buf_ff[pos[5:2]] <= lane_word(req_tdata, 2'd0);
               else
                  buf_ff[pos[5:2]] <= buf_ff[pos[5:2]] | lane_word(req_tdata, pos[1:0]);
            end
         end
         ST_PAD: begin
            for (int i = 0; i < 16; i++) begin
               if (pos < 6'd56 && i == 14) begin
                  buf_ff[i] <= bits[63:32];
               end else if (pos < 6'd56 && i == 15) begin
                  buf_ff[i] <= bits[31:0];
               end else if (4'(i) == pos[5:2]) begin
                  if (pos[1:0] == 2'd0) buf_ff[i] <= lane_word(PAD_BYTE, 2'd0);
                  else buf_ff[i] <= buf_ff[i] | lane_word(PAD_BYTE, pos[1:0]);
               end else if (4'(i) > pos[5:2]) begin
                  buf_ff[i] <= '0;
               end
            end
         end
         ST_FOLD: begin
            // extra block holds only the length
            if (!fin_ff && pad2_ff) begin
               for (int i = 0; i < 14; i++) buf_ff[i] <= '0;
               buf_ff[14] <= bits[63:32];
               buf_ff[15] <= bits[31:0];
            end
         end
         default: ;
      endcase
   end

   // length and message-end bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         fin_ff  <= 1'b0;
         pad2_ff <= 1'b0;
         emit_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (acc) begin
                  if (!req_tuser) len_ff <= len_ff + 61'd1;
                  if (req_tlast) begin
                     emit_ff <= 1'b1;
                     fin_ff  <= fill;  // full block first, then padding
                  end
               end
            end
            ST_PAD: begin
               fin_ff  <= 1'b0;
               pad2_ff <= (pos >= 6'd56);
            end
            ST_FOLD: begin
               if (!fin_ff && pad2_ff) pad2_ff <= 1'b0;
            end
            ST_EMIT: begin
               if (rsp_tready) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     emit_ff <= 1'b0;
                     len_ff  <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_tdata = hash[(7-idx_ff)*32 +: 32];
   assign rsp_tlast = (idx_ff == 3'd7);
   assign rsp_tuser = idx_ff;

   initial_guard: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accepting during emit");
   assert property (@(posedge clock) disable iff (reset)
      ctl.done |-> !ctl.busy) else $error("fold while rounds run");
   assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !ctl.busy) else $error("start while rounds run");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("digest word changed while waiting");

endmodule

[dv/sha256_message_hasher_unit_test.sv]
// ----------------------------------------------------------------------------
// SHA-256 message hasher testbench
// Streams messages byte by byte with random gaps and back-pressure, computes
// the expected digest words alongside, and compares every digest word out.
// ----------------------------------------------------------------------------
module sha256_message_hasher_unit_test;
   import sha256_pkg::*;

   typedef struct packed {
      logic [31:0] digest;
      logic [2:0]  index;
      logic        final_word;
   } digest_word_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;

   // Expected digest words and the running hash state
   digest_word_type expected_words[$];
   logic [31:0]     hash_state[8];
   logic [31:0]     block_words[16];
   logic [60:0]     byte_count;

   int mismatch_count;
   int idle_cycles;
   bit hold_off;

   sha256_message_hasher_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tlast(req_tlast), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // SHA-256 constants, kept local to the predictor
   localparam logic [31:0] IV_WORDS[8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
   localparam logic [31:0] K_WORDS[64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic logic [31:0] ror32(logic [31:0] v, int s);
      return (v >> s) | (v << (32 - s));
   endfunction

   // Fold the current block into the hash state
   task automatic compress_into_state();
      logic [31:0] w[64];
      logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
      for (int t = 0; t < 16; t++) w[t] = block_words[t];
      for (int t = 16; t < 64; t++)
         w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
              + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
      e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
      for (int t = 0; t < 64; t++) begin
         t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
            + K_WORDS[t] + w[t];
         t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
      hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
   endtask

   task automatic place_byte(int pos, logic [7:0] b);
      logic [31:0] lane_val;
      lane_val = {24'd0, b} << ((3 - pos % 4) * 8);
      if (pos % 4 == 0) block_words[pos / 4] = lane_val;
      else block_words[pos / 4] |= lane_val;
   endtask

   // Update the hash state for one accepted word; queue the digest at message end
   task automatic predict_digest(logic [7:0] data, logic is_last, logic no_byte);
      int pos;
      logic [63:0] bit_len;
      digest_word_type dw;
      if (!no_byte) begin
         pos = byte_count[5:0];
         place_byte(pos, data);
         byte_count = byte_count + 61'd1;
         if (pos == 63) compress_into_state();
      end
      if (!is_last) return;
      pos = byte_count[5:0];
      place_byte(pos, 8'h80);
      for (int i = pos / 4 + 1; i < 16; i++) block_words[i] = '0;
      if (pos >= 56) begin
         compress_into_state();
         for (int i = 0; i < 14; i++) block_words[i] = '0;
      end
      bit_len = {byte_count, 3'b000};
      block_words[14] = bit_len[63:32];
      block_words[15] = bit_len[31:0];
      compress_into_state();
      for (int k = 0; k < 8; k++) begin
         dw.digest = hash_state[k];
         dw.index = 3'(k);
         dw.final_word = (k == 7);
         expected_words.push_back(dw);
      end
      hash_state = IV_WORDS;
      byte_count = '0;
   endtask

   // Offer one word after a random gap, hold until accepted
   task automatic send_word(logic [7:0] data, logic is_last, logic no_byte);
      int gap;
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= is_last;
      req_tuser  <= no_byte;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_digest(data, is_last, no_byte);
      @(negedge clock);
   endtask

   task automatic send_message(int len, bit empty_tail, bit idle_words);
      for (int i = 0; i < len; i++) begin
         if (idle_words && $urandom_range(0, 7) == 0) send_word(8'($urandom), 1'b0, 1'b1);
         if (i == len - 1 && !empty_tail) send_word(8'($urandom), 1'b1, 1'b0);
         else send_word(8'($urandom), 1'b0, 1'b0);
      end
      if (empty_tail || len == 0) send_word(8'($urandom), 1'b1, 1'b1);
   endtask

   task automatic test_directed_edges();
      // Empty message, then one-byte messages at the byte extremes
      send_word(8'h00, 1'b1, 1'b1);
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hff, 1'b1, 1'b0);
      // Idle word without data, then a byte and an empty end marker
      send_word(8'h5a, 1'b0, 1'b1);
      send_word(8'ha5, 1'b0, 1'b0);
      send_word(8'h3c, 1'b1, 1'b1);
   endtask

   task automatic test_padding_boundaries();
      // Lengths around the extra-block boundary and full block
      send_message(55, 1'b0, 1'b0);
      send_message(56, 1'b0, 1'b0);
      send_message(64, 1'b1, 1'b0);
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      send_message(3, 1'b0, 1'b0);
      send_message(2, 1'b0, 1'b0);
      hold_off = 1'b0;
   endtask

   task automatic test_random_messages();
      int sent;
      int len;
      sent = 0;
      while (sent < 110) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
         send_message(len, $urandom_range(0, 3) == 0, 1'b1);
         sent += len + 1;
      end
   endtask

   // Drive ready with random stalls, or hold off for a long stretch on request
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            rsp_tready <= 1'b1;
            @(negedge clock);
            while (hold_off) @(negedge clock);
         end else begin
            stall = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Compare each accepted digest word with the oldest expectation
   always @(posedge clock) begin
      digest_word_type exp_word;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected digest word %h index %0d", rsp_tdata, rsp_tuser);
         end else begin
            exp_word = expected_words.pop_front();
            if (rsp_tdata !== exp_word.digest || rsp_tuser !== exp_word.index ||
                rsp_tlast !== exp_word.final_word) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("digest word mismatch: expected %h/%0d/%0b got %h/%0d/%0b",
                           exp_word.digest, exp_word.index, exp_word.final_word,
                           rsp_tdata, rsp_tuser, rsp_tlast);
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 3000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      req_tuser = 1'b0;
      hold_off = 1'b0;
      hash_state = IV_WORDS;
      block_words = '{default: '0};
      byte_count = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_edges();
      test_padding_boundaries();
      test_backpressure();
      test_random_messages();
      req_tvalid <= 1'b0;

      // Drain remaining digest words, then let the block settle
      while (expected_words.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
